FILE: rtl/core/walkable_voxel_filter_assert.svh
// Assertion macros for the walkable voxel filter.
// Expects clk and rst_n in the scope of the including module.
`ifndef WALKABLE_VOXEL_FILTER_ASSERT_SVH
`define WALKABLE_VOXEL_FILTER_ASSERT_SVH

// same-cycle implication, inactive while reset is held
`define WVF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, inactive while reset is held
`define WVF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wvf_pkg.sv
// Shared types and constants of the walkable voxel filter.
// No dependencies; used by wvf_colcheck and walkable_voxel_filter.
package wvf_pkg;

  // fixed field widths of the ports
  localparam int unsigned XW       = 6;
  localparam int unsigned YW       = 5;
  localparam int unsigned ZW       = 6;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned CFG_DW   = 7;
  // compare width for dimensions up to 2047
  localparam int unsigned CW       = 11;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_WIDTH_USED    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT_USED   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_DEPTH_USED    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT_VOXELS = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_RADIUS_VOXELS = 3'd4;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_WRRD,
    S_WRWB,
    S_CTR,
    S_CTREV,
    S_SCAN,
    S_DONE
  } wvf_state_t;

  // flags of one column at the query level and one level below
  typedef struct packed {
    logic floor_y;
    logic clear_y;
    logic clear_ym1;
  } col_flags_t;

endpackage

FILE: rtl/core/wvf_colmem.sv
// Solid-voxel column store: one word of vertical solid bits per (x, z).
// One write port, one read port with registered read data. Uses no package.
module wvf_colmem #(
  parameter int unsigned ROWS = 4096,
  parameter int unsigned WORD = 32,
  parameter int unsigned RAW  = 12
) (
  input  logic            clk,
  input  logic            we,
  input  logic [RAW-1:0]  waddr,
  input  logic [WORD-1:0] wdata,
  input  logic            re,
  input  logic [RAW-1:0]  raddr,
  output logic [WORD-1:0] rdata
);

  logic [WORD-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/wvf_colcheck.sv
// Shared column test unit: floor and headroom flags of one column word.
// Depends on wvf_pkg for col_flags_t and field widths.
module wvf_colcheck #(
  parameter int unsigned GRID_HEIGHT = 32
) (
  input  logic [GRID_HEIGHT-1:0]   col,
  input  logic [wvf_pkg::YW-1:0]   lvl_y,
  input  logic [5:0]               hv,
  input  logic [wvf_pkg::CW-1:0]   eff_h,
  output wvf_pkg::col_flags_t      flags
);
  import wvf_pkg::*;

  // empty cell at lvl with a solid cell under it, inside the used height
  function automatic logic floor_at(input logic [GRID_HEIGHT-1:0] c, input int lvl,
                                    input int effh);
    logic f;
    f = 1'b0;
    for (int j = 1; j < GRID_HEIGHT; j++) begin
      if (j == lvl && j < effh && !c[j] && c[j-1]) begin
        f = 1'b1;
      end
    end
    return f;
  endfunction

  // any solid cell in lvl+1 .. lvl+height-1, stopping at the used height
  function automatic logic blocked_at(input logic [GRID_HEIGHT-1:0] c, input int lvl,
                                      input int h, input int effh);
    logic b;
    b = 1'b0;
    for (int j = 0; j < GRID_HEIGHT; j++) begin
      if (j > lvl && j < lvl + h && j < effh && c[j]) begin
        b = 1'b1;
      end
    end
    return b;
  endfunction

  int lvl0;
  int lvl1;
  int h_i;
  int effh_i;

  always_comb begin
    lvl0   = int'(lvl_y);
    lvl1   = lvl0 - 1;
    h_i    = int'(hv);
    effh_i = int'(eff_h);
    flags.floor_y   = floor_at(col, lvl0, effh_i);
    flags.clear_y   = flags.floor_y && !blocked_at(col, lvl0, h_i, effh_i);
    // level below only exists above the bottom row
    flags.clear_ym1 = (lvl_y != '0) && floor_at(col, lvl1, effh_i)
                      && !blocked_at(col, lvl1, h_i, effh_i);
  end

endmodule

FILE: rtl/core/walkable_voxel_filter.sv
// Walkable voxel filter: solid-voxel store with walkability queries.
// Input channel (in_valid/in_stall): mode 0 writes one solid bit at
// (cell_x, cell_y, cell_z), mode 1 queries that cell. Result channel
// (out_valid/out_stall) carries one transaction per query with floor_flag,
// clear_above and walkable; writes give no result.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets used grid
// size, agent height and radius; write it only while the block is idle.
// A write holds the input while it reads a column word, sets or clears the bit
// and writes it back. A query reads the center column, then one neighbor column
// per cycle until the square of the agent radius is checked; a query that fails
// early or is out of range ends sooner. The single read port of the column
// store sets the pace of the scan. One item is in work at a time.
// Reset: the store is cleared by a pass over all GRID_WIDTH*GRID_DEPTH
// column words (4096 by default); in_stall stays high until it ends.
// A result waiting under out_stall sits in the output register; the next
// item is still taken, but its result is held until the register frees.
// Depends on wvf_pkg, wvf_colmem, wvf_colcheck and the assert header.
module walkable_voxel_filter #(
  parameter int unsigned GRID_WIDTH  = 64,
  parameter int unsigned GRID_HEIGHT = 32,
  parameter int unsigned GRID_DEPTH  = 64,
  parameter int unsigned MAX_RADIUS  = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [wvf_pkg::XW-1:0]      in_cell_x,
  input  logic [wvf_pkg::YW-1:0]      in_cell_y,
  input  logic [wvf_pkg::ZW-1:0]      in_cell_z,
  input  logic                        in_solid_bit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_floor_flag,
  output logic                        out_clear_above,
  output logic                        out_walkable,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wvf_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [wvf_pkg::CFG_DW-1:0]  cfg_data
);
  import wvf_pkg::*;

  `include "walkable_voxel_filter_assert.svh"

  localparam int unsigned ROWS = GRID_WIDTH * GRID_DEPTH;
  localparam int unsigned RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [CW-1:0]  GW = CW'(GRID_WIDTH);
  localparam logic [CW-1:0]  GH = CW'(GRID_HEIGHT);
  localparam logic [CW-1:0]  GD = CW'(GRID_DEPTH);
  localparam logic [4:0]     MR = 5'(MAX_RADIUS);
  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

  function automatic logic [RAW-1:0] row_addr(input logic [6:0] xx, input logic [6:0] zz);
    logic [31:0] a;
    a = 32'(zz) * 32'(GRID_WIDTH) + 32'(xx);
    return a[RAW-1:0];
  endfunction

  // configuration registers
  logic [6:0] width_used_r;
  logic [5:0] height_used_r;
  logic [6:0] depth_used_r;
  logic [5:0] height_voxels_r;
  logic [2:0] radius_voxels_r;

  // sequencer state
  wvf_state_t      state_r, state_nxt;
  logic [RAW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic            mode_r, mode_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [ZW-1:0]   z_r, z_nxt;
  logic            solid_r, solid_nxt;
  logic signed [7:0] nx_r, nx_nxt;
  logic signed [7:0] nz_r, nz_nxt;
  logic            iss_done_r, iss_done_nxt;
  logic            pend_r, pend_nxt;
  logic            res_floor_r, res_floor_nxt;
  logic            res_clear_r, res_clear_nxt;
  logic            ok_r, ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_floor_r, out_floor_nxt;
  logic            out_clear_r, out_clear_nxt;
  logic            out_walk_r, out_walk_nxt;

  // derived values
  logic [CW-1:0]    eff_w, eff_h, eff_d;
  logic [2:0]       r_eff;
  logic signed [7:0] x_lo, x_hi, z_lo, z_hi;
  logic             in_acc, in_rng, n_oob;

  // store ports
  logic                   mem_we, mem_re;
  logic [RAW-1:0]         mem_waddr, mem_raddr;
  logic [GRID_HEIGHT-1:0] mem_wdata, mem_rdata;
  col_flags_t             cflags;

  wvf_colmem #(
    .ROWS (ROWS),
    .WORD (GRID_HEIGHT),
    .RAW  (RAW)
  ) u_colmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wvf_colcheck #(
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_colcheck (
    .col   (mem_rdata),
    .lvl_y (y_r),
    .hv    (height_voxels_r),
    .eff_h (eff_h),
    .flags (cflags)
  );

  assign eff_w = (CW'(width_used_r) < GW) ? CW'(width_used_r) : GW;
  assign eff_h = (CW'(height_used_r) < GH) ? CW'(height_used_r) : GH;
  assign eff_d = (CW'(depth_used_r) < GD) ? CW'(depth_used_r) : GD;
  assign r_eff = (5'(radius_voxels_r) < MR) ? radius_voxels_r : MR[2:0];

  assign x_lo = $signed({2'b00, x_r}) - $signed({5'b00000, r_eff});
  assign x_hi = $signed({2'b00, x_r}) + $signed({5'b00000, r_eff});
  assign z_lo = $signed({2'b00, z_r}) - $signed({5'b00000, r_eff});
  assign z_hi = $signed({2'b00, z_r}) + $signed({5'b00000, r_eff});

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_rng    = (CW'(in_cell_x) < eff_w) && (CW'(in_cell_y) < eff_h)
                     && (CW'(in_cell_z) < eff_d);
  assign n_oob     = nx_r[7] || nz_r[7] || ({4'b0000, nx_r[6:0]} >= eff_w)
                     || ({4'b0000, nz_r[6:0]} >= eff_d);

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_floor_flag  = out_floor_r;
  assign out_clear_above = out_clear_r;
  assign out_walkable    = out_walk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_used_r    <= 7'd64;
      height_used_r   <= 6'd32;
      depth_used_r    <= 7'd64;
      height_voxels_r <= 6'd2;
      radius_voxels_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH_USED:    width_used_r    <= cfg_data;
        CFG_HEIGHT_USED:   height_used_r   <= cfg_data[5:0];
        CFG_DEPTH_USED:    depth_used_r    <= cfg_data;
        CFG_HEIGHT_VOXELS: height_voxels_r <= cfg_data[5:0];
        CFG_RADIUS_VOXELS: radius_voxels_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      iss_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      iss_done_r  <= iss_done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    solid_r     <= solid_nxt;
    nx_r        <= nx_nxt;
    nz_r        <= nz_nxt;
    res_floor_r <= res_floor_nxt;
    res_clear_r <= res_clear_nxt;
    ok_r        <= ok_nxt;
    out_floor_r <= out_floor_nxt;
    out_clear_r <= out_clear_nxt;
    out_walk_r  <= out_walk_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    solid_nxt     = solid_r;
    nx_nxt        = nx_r;
    nz_nxt        = nz_r;
    iss_done_nxt  = iss_done_r;
    pend_nxt      = 1'b0;
    res_floor_nxt = res_floor_r;
    res_clear_nxt = res_clear_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_floor_nxt = out_floor_r;
    out_clear_nxt = out_clear_r;
    out_walk_nxt  = out_walk_r;
    mem_we        = 1'b0;
    mem_waddr     = row_addr({1'b0, x_r}, {1'b0, z_r});
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = row_addr({1'b0, x_r}, {1'b0, z_r});

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt  = in_mode;
          x_nxt     = in_cell_x;
          y_nxt     = in_cell_y;
          z_nxt     = in_cell_z;
          solid_nxt = in_solid_bit;
          if (in_mode == MODE_WRITE) begin
            // drop writes outside the used grid
            if (in_rng) begin
              state_nxt = S_WRRD;
            end
          end else if (in_rng) begin
            state_nxt = S_CTR;
          end else begin
            res_floor_nxt = 1'b0;
            res_clear_nxt = 1'b0;
            ok_nxt        = 1'b0;
            state_nxt     = S_DONE;
          end
        end
      end
      S_WRRD: begin
        mem_re    = 1'b1;
        state_nxt = S_WRWB;
      end
      S_WRWB: begin
        mem_we = 1'b1;
        for (int j = 0; j < GRID_HEIGHT; j++) begin
          if (j == int'(y_r)) begin
            mem_wdata[j] = solid_r;
          end
        end
        state_nxt = S_IDLE;
      end
      S_CTR: begin
        mem_re    = 1'b1;
        state_nxt = S_CTREV;
      end
      S_CTREV: begin
        res_floor_nxt = cflags.floor_y;
        res_clear_nxt = cflags.clear_y;
        ok_nxt        = cflags.clear_y;
        nx_nxt        = x_lo;
        nz_nxt        = z_lo;
        iss_done_nxt  = 1'b0;
        state_nxt     = cflags.clear_y ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        // issue one neighbor column read a cycle, row by row
        if (!iss_done_r) begin
          if (n_oob) begin
            ok_nxt    = 1'b0;
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = row_addr(nx_r[6:0], nz_r[6:0]);
            pend_nxt  = 1'b1;
            if (nx_r == x_hi) begin
              nx_nxt = x_lo;
              if (nz_r == z_hi) begin
                iss_done_nxt = 1'b1;
              end else begin
                nz_nxt = nz_r + 8'sd1;
              end
            end else begin
              nx_nxt = nx_r + 8'sd1;
            end
          end
        end
        // check the column read in the previous cycle
        if (pend_r && !(cflags.clear_y || cflags.clear_ym1)) begin
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
        if (iss_done_r && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_floor_nxt = res_floor_r;
          out_clear_nxt = res_clear_r;
          out_walk_nxt  = ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `WVF_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
                  "result loaded outside the done state")
  `WVF_ASSERT_IMP(a_eval_after_issue, pend_r,
                  $past(state_r) == S_SCAN && $past(mem_re),
                  "neighbor check without a read issued in the scan")
  `WVF_ASSERT_IMP(a_store_write_rmw, mem_we && state_r != S_CLR,
                  state_r == S_WRWB && $past(state_r) == S_WRRD,
                  "store written without a preceding column read")
  `WVF_ASSERT_NXT(a_walk_needs_clear, state_r == S_DONE && ok_r, res_clear_r || out_clear_r,
                  "walkable result without clear_above")

endmodule

FILE: tb/walkable_voxel_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for walkable_voxel_filter: a cycle-free model of the
// voxel store predicts the flags of every query. Depends on wvf_pkg and the RTL.
module walkable_voxel_filter_tb;
  import wvf_pkg::*;

  localparam int GRID_W        = 64;
  localparam int GRID_H        = 32;
  localparam int GRID_D        = 64;
  localparam int RADIUS_MAX    = 7;
  localparam int ITEM_TARGET   = 1250;
  localparam int PRESET_PHASES = 11;
  localparam int SETTLE_CYCLES = 250;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int MAX_SHOWN     = 10;
  localparam logic [CFG_IW-1:0] CFG_UNUSED_LO = 3'd5;

  typedef struct packed {
    logic floor_flag;
    logic clear_above;
    logic walkable;
  } cell_flags_t;

  typedef struct packed {
    logic          mode;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [ZW-1:0] z;
    logic          solid;
  } voxel_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_WRITE;
  logic [XW-1:0]     in_cell_x = '0;
  logic [YW-1:0]     in_cell_y = '0;
  logic [ZW-1:0]     in_cell_z = '0;
  logic              in_solid_bit = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_floor_flag;
  logic              out_clear_above;
  logic              out_walkable;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  // model of the block: solid bits and register copies
  bit          solid_map [0:GRID_W*GRID_H*GRID_D-1];
  logic [6:0]  width_reg  = 7'd64;
  logic [5:0]  height_reg = 6'd32;
  logic [6:0]  depth_reg  = 7'd64;
  logic [5:0]  hv_reg     = 6'd2;
  logic [2:0]  radius_reg = 3'd1;

  voxel_op_t   voxel_ops[$];
  cell_flags_t predicted_flags[$];
  voxel_op_t   cur_op;
  bit          op_taken = 1'b0;
  bit          no_gaps = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;
  int          phase_ops = 0;
  int          total_ops = 0;

  walkable_voxel_filter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_z      (in_cell_z),
    .in_solid_bit   (in_solid_bit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_floor_flag (out_floor_flag),
    .out_clear_above(out_clear_above),
    .out_walkable   (out_walkable),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int eff_w();
    return (int'(width_reg) < GRID_W) ? int'(width_reg) : GRID_W;
  endfunction

  function automatic int eff_h();
    return (int'(height_reg) < GRID_H) ? int'(height_reg) : GRID_H;
  endfunction

  function automatic int eff_d();
    return (int'(depth_reg) < GRID_D) ? int'(depth_reg) : GRID_D;
  endfunction

  function automatic int eff_r();
    return (int'(radius_reg) < RADIUS_MAX) ? int'(radius_reg) : RADIUS_MAX;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < eff_w() && y < eff_h() && z < eff_d();
  endfunction

  function automatic bit is_solid(int x, int y, int z);
    if (!in_grid(x, y, z))
      return 1'b0;
    return solid_map[(y * GRID_D + z) * GRID_W + x];
  endfunction

  function automatic bit is_floor(int x, int y, int z);
    if (!in_grid(x, y, z) || y < 1)
      return 1'b0;
    return !is_solid(x, y, z) && is_solid(x, y - 1, z);
  endfunction

  function automatic bit is_clear(int x, int y, int z);
    if (!is_floor(x, y, z))
      return 1'b0;
    for (int h = 1; h < int'(hv_reg); h++) begin
      if (y + h >= eff_h())
        break;
      if (is_solid(x, y + h, z))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cell_flags_t predict_cell_flags(int x, int y, int z);
    cell_flags_t f;
    int r;
    r = eff_r();
    f.floor_flag  = is_floor(x, y, z);
    f.clear_above = is_clear(x, y, z);
    f.walkable    = f.clear_above;
    if (f.walkable) begin
      for (int dz = -r; dz <= r; dz++) begin
        for (int dx = -r; dx <= r; dx++) begin
          if (x + dx < 0 || z + dz < 0 || x + dx >= eff_w() || z + dz >= eff_d())
            f.walkable = 1'b0;
          else if (!is_clear(x + dx, y, z + dz) &&
                   !(y > 0 && is_clear(x + dx, y - 1, z + dz)))
            f.walkable = 1'b0;
        end
      end
    end
    return f;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // queue one transaction; coordinates outside the port fields are dropped
  task automatic push_op(input logic mode, input int x, input int y, input int z,
                         input logic sbit);
    voxel_op_t op;
    if (x < 0 || y < 0 || z < 0 || x >= (1 << XW) || y >= (1 << YW) || z >= (1 << ZW))
      return;
    op.mode  = mode;
    op.x     = x[XW-1:0];
    op.y     = y[YW-1:0];
    op.z     = z[ZW-1:0];
    op.solid = sbit;
    voxel_ops.insert(voxel_ops.size(), op);
    phase_ops++;
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH_USED:    width_reg  = data[6:0];
      CFG_HEIGHT_USED:   height_reg = data[5:0];
      CFG_DEPTH_USED:    depth_reg  = data[6:0];
      CFG_HEIGHT_VOXELS: hv_reg     = data[5:0];
      CFG_RADIUS_VOXELS: radius_reg = data[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every transaction and result, then let trailing writes settle
  task automatic drain();
    while (voxel_ops.size() != 0 || in_valid)
      @(posedge clk);
    while (predicted_flags.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || op_taken) begin
      if (voxel_ops.size() != 0 && (no_gaps || $urandom_range(99) >= 10)) begin
        cur_op = voxel_ops.pop_front();
        in_valid     <= 1'b1;
        in_mode      <= cur_op.mode;
        in_cell_x    <= cur_op.x;
        in_cell_y    <= cur_op.y;
        in_cell_z    <= cur_op.z;
        in_solid_bit <= cur_op.solid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // update the model on each accepted transaction
  always @(posedge clk) begin
    op_taken = rst_n && in_valid && !in_stall;
    if (op_taken) begin
      if (cur_op.mode == MODE_WRITE) begin
        if (in_grid(int'(cur_op.x), int'(cur_op.y), int'(cur_op.z)))
          solid_map[(int'(cur_op.y) * GRID_D + int'(cur_op.z)) * GRID_W + int'(cur_op.x)] =
            cur_op.solid;
      end else begin
        predicted_flags.insert(predicted_flags.size(),
                               predict_cell_flags(int'(cur_op.x), int'(cur_op.y),
                                                  int'(cur_op.z)));
      end
    end
  end

  always @(negedge clk)
    out_stall <= !no_gaps && ($urandom_range(99) < 10);

  // result monitor
  always @(posedge clk) begin
    cell_flags_t want;
    cell_flags_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_floor_flag, out_clear_above, out_walkable};
      if (predicted_flags.size() == 0) begin
        note_mismatch($sformatf("result with none pending: floor=%0b clear=%0b walk=%0b",
                                got.floor_flag, got.clear_above, got.walkable));
      end else begin
        want = predicted_flags.pop_front();
        if (got !== want)
          note_mismatch($sformatf(
            "floor exp %0b got %0b, clear exp %0b got %0b, walk exp %0b got %0b",
            want.floor_flag, got.floor_flag, want.clear_above, got.clear_above,
            want.walkable, got.walkable));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int ph, budget, w, h, d, hv, r;
    int ew, eh, ed, sp, y, cx, cz, roll, nq;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold off until the clearing pass ends
    do @(posedge clk); while (in_stall);

    // directed part at reset settings
    push_op(MODE_QUERY, 0, 0, 0, 1'b0);
    push_op(MODE_WRITE, 63, 31, 63, 1'b1);
    push_op(MODE_QUERY, 63, 31, 63, 1'b0);
    for (int dz = -1; dz <= 1; dz++)
      for (int dx = -1; dx <= 1; dx++)
        push_op(MODE_WRITE, 10 + dx, 4, 10 + dz, 1'b1);
    push_op(MODE_QUERY, 10, 5, 10, 1'b1);
    push_op(MODE_WRITE, 10, 6, 10, 1'b1);
    push_op(MODE_QUERY, 10, 5, 10, 1'b0);
    push_op(MODE_WRITE, 10, 6, 10, 1'b0);
    push_op(MODE_QUERY, 10, 5, 10, 1'b0);
    push_op(MODE_QUERY, 9, 5, 9, 1'b0);
    push_op(MODE_WRITE, 0, 0, 0, 1'b1);
    push_op(MODE_QUERY, 0, 1, 0, 1'b0);
    push_op(MODE_WRITE, 63, 0, 63, 1'b1);
    push_op(MODE_QUERY, 63, 1, 63, 1'b1);
    push_op(MODE_WRITE, 5, 30, 5, 1'b1);
    push_op(MODE_QUERY, 5, 31, 5, 1'b0);
    drain();
    total_ops = phase_ops;

    ph = 1;
    while (ph <= PRESET_PHASES || total_ops < ITEM_TARGET) begin
      budget = 110;
      case (ph)
        1:  begin w = 64;  h = 32;  d = 64;  hv = 2;   r = 1; end
        2:  begin w = 127; h = 63;  d = 127; hv = 0;   r = 0; end
        3:  begin w = 20;  h = 12;  d = 24;  hv = 1;   r = 2; end
        4:  begin w = 0;   h = 32;  d = 64;  hv = 2;   r = 1; budget = 30; end
        5:  begin w = 64;  h = 0;   d = 64;  hv = 3;   r = 1; budget = 30; end
        6:  begin w = 40;  h = 32;  d = 40;  hv = 32;  r = 7; end
        7:  begin w = 64;  h = 20;  d = 64;  hv = 63;  r = 3; end
        8:  begin w = 1;   h = 1;   d = 1;   hv = 1;   r = 0; budget = 30; end
        9:  begin w = 64;  h = 32;  d = 0;   hv = 2;   r = 1; budget = 30; end
        10: begin w = 16;  h = 2;   d = 16;  hv = 5;   r = 4; end
        11: begin w = 127; h = 127; d = 127; hv = 127; r = 127; end
        default: begin
          w  = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(64, 8);
          h  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(32, 3);
          d  = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(64, 8);
          hv = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6);
          r  = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2);
        end
      endcase
      no_gaps = (ph == 1);
      cfg_write(CFG_WIDTH_USED, w[CFG_DW-1:0]);
      cfg_write(CFG_HEIGHT_USED, h[CFG_DW-1:0]);
      cfg_write(CFG_DEPTH_USED, d[CFG_DW-1:0]);
      cfg_write(CFG_HEIGHT_VOXELS, hv[CFG_DW-1:0]);
      cfg_write(CFG_RADIUS_VOXELS, r[CFG_DW-1:0]);
      if (ph == PRESET_PHASES || $urandom_range(2) == 0)
        cfg_write(CFG_UNUSED_LO + CFG_IW'($urandom_range(2)), CFG_DW'($urandom_range(127)));

      ew = eff_w();
      eh = eff_h();
      ed = eff_d();
      phase_ops = 0;
      while (phase_ops < budget) begin
        if ($urandom_range(99) < 75) begin
          // floor patch around a standing cell, then queries on and around it
          r  = eff_r();
          sp = r + (($urandom_range(3) == 0) ? 1 : 0);
          y  = (eh >= 2 && $urandom_range(99) < 90) ? $urandom_range(eh - 1, 1)
                                                    : $urandom_range(31);
          cx = (ew > 2 * r && $urandom_range(99) < 85) ? $urandom_range(ew - 1 - r, r)
                                                       : $urandom_range(63);
          cz = (ed > 2 * r && $urandom_range(99) < 85) ? $urandom_range(ed - 1 - r, r)
                                                       : $urandom_range(63);
          for (int dz = -sp; dz <= sp; dz++) begin
            for (int dx = -sp; dx <= sp; dx++) begin
              roll = $urandom_range(99);
              if (roll < 8 && y >= 2) begin
                // step down one level
                push_op(MODE_WRITE, cx + dx, y - 2, cz + dz, 1'b1);
                push_op(MODE_WRITE, cx + dx, y - 1, cz + dz, 1'b0);
              end else if (roll < 12) begin
                push_op(MODE_WRITE, cx + dx, y - 1, cz + dz, 1'b0);
              end else begin
                push_op(MODE_WRITE, cx + dx, y - 1, cz + dz, 1'b1);
              end
              if ($urandom_range(3) == 0)
                push_op(MODE_WRITE, cx + dx, y, cz + dz, 1'b0);
            end
          end
          if ($urandom_range(2) == 0)
            push_op(MODE_WRITE, cx + int'($urandom_range(2 * r)) - r,
                    y + 1 + int'($urandom_range(int'(hv_reg))),
                    cz + int'($urandom_range(2 * r)) - r, 1'b1);
          push_op(MODE_QUERY, cx, y, cz, 1'($urandom_range(1)));
          nq = $urandom_range(3);
          repeat (nq)
            push_op(MODE_QUERY, cx + int'($urandom_range(2 * sp)) - sp,
                    y - (($urandom_range(5) == 0) ? 1 : 0),
                    cz + int'($urandom_range(2 * sp)) - sp, 1'($urandom_range(1)));
        end else begin
          repeat (1 + $urandom_range(2))
            push_op(1'($urandom_range(1)), $urandom_range(63), $urandom_range(31),
                    $urandom_range(63), 1'($urandom_range(1)));
        end
      end
      drain();
      total_ops += phase_ops;
      ph++;
    end

    if (mismatches == 0 && predicted_flags.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/wvf_pkg.sv
rtl/core/wvf_colmem.sv
rtl/core/wvf_colcheck.sv
rtl/core/walkable_voxel_filter.sv
tb/walkable_voxel_filter_tb.sv
